@@ sv/note_on_off_pairing_assert.svh @@
// ----------------------------------------------------------------------------
// note_on_off_pairing_assert
// Assertion macros for the note pairing RTL.
// ----------------------------------------------------------------------------
`ifndef NOTE_ON_OFF_PAIRING_ASSERT_SVH
`define NOTE_ON_OFF_PAIRING_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define NOP_ASSERT_NOW(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("note pairing check failed");

// Condition holds in the cycle after the trigger.
`define NOP_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("note pairing check failed");

`endif

@@ sv/nop_pkg.sv @@
// ----------------------------------------------------------------------------
// nop_pkg
// Types and constants for the note-on/note-off pairing block.
// ----------------------------------------------------------------------------
package nop_pkg;

    localparam int PENDING_DEPTH = 16;

    localparam logic       KIND_ON  = 1'b0;
    localparam logic       KIND_OFF = 1'b1;

    localparam logic [2:0] ST_STORED   = 3'd0;
    localparam logic [2:0] ST_DONE     = 3'd1;
    localparam logic [2:0] ST_NOMATCH  = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_DISABLED = 3'd4;

    typedef struct packed {
        logic        kind;
        logic [3:0]  channel;
        logic [6:0]  pitch;
        logic [6:0]  velocity;
        logic [31:0] current_tick;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] start_tick;
        logic [31:0] end_tick;
        logic [6:0]  note_pitch;
        logic [6:0]  note_velocity;
        logic [3:0]  note_channel;
    } out_t;

    // One open note as held in a cell
    typedef struct packed {
        logic [31:0] start;
        logic [6:0]  pitch;
        logic [6:0]  velocity;
        logic [3:0]  channel;
    } entry_t;

    // Broadcast from the sequencer to every cell
    typedef struct packed {
        logic   capture;   // latch per-cell match flag
        logic   commit;    // apply append or removal
        logic   is_off;
        entry_t ev;        // event as an entry (key for a note-off)
    } cell_ctrl_t;

endpackage

@@ sv/nop_cell.sv @@
// ----------------------------------------------------------------------------
// nop_cell
// One slot of the open-note chain: holds an entry, matches it against the
// event key and shifts in from its right neighbor on removal.
// ----------------------------------------------------------------------------
module nop_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  nop_pkg::cell_ctrl_t ctrl,
    input  logic                left_valid,
    input  logic                kill_in,
    input  logic                right_valid,
    input  nop_pkg::entry_t     right_entry,
    output logic                kill_out,
    output logic                found,
    output logic                valid,
    output nop_pkg::entry_t     entry
);
    import nop_pkg::*;

    logic   valid_reg, valid_next;
    entry_t entry_reg, entry_next;
    logic   match_reg;

    // an older cell already matched: this one only shifts
    assign found    = match_reg & ~kill_in;
    assign kill_out = match_reg | kill_in;
    assign valid    = valid_reg;
    assign entry    = entry_reg;

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (ctrl.commit)
        begin
            if (ctrl.is_off)
            begin
                if (kill_out)
                begin
                    valid_next = right_valid;
                    entry_next = right_entry;
                end
            end
            else if (!valid_reg && left_valid)
            begin
                valid_next = 1'b1;
                entry_next = ctrl.ev;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctrl.capture)
            begin
                match_reg <= valid_reg && entry_reg.pitch == ctrl.ev.pitch
                             && entry_reg.channel == ctrl.ev.channel;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

@@ sv/note_on_off_pairing.sv @@
// ----------------------------------------------------------------------------
// note_on_off_pairing
// Pairs note-on and note-off events into finished notes.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data) carries one event per transfer;
// output channel (out_valid/out_ready/out_data) returns exactly one result per
// event, in order. cfg_write/cfg_data load record_enable; write it only idle.
// Open notes live in a chain of PENDING_DEPTH cells, oldest in cell 0.
// Each event goes through accept, per-cell match capture, then resolve,
// where the oldest match is found along the chain, cells at and past it shift
// left by one, and the result is loaded into the output register. A new event
// is accepted in the cycle after the result is loaded; events are taken one
// at a time, with no new one accepted while one is still in progress.
// When the receiver stalls, the result waits in the output register and the
// next event is still accepted and matched; it holds in the resolve step
// until the output register frees.
// Reset clears all cell valid bits, the output register and record_enable.
// ----------------------------------------------------------------------------
module note_on_off_pairing (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  nop_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output nop_pkg::out_t out_data,
    input  logic          cfg_write,
    input  logic          cfg_data
);
    import nop_pkg::*;

    `include "note_on_off_pairing_assert.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_RESOLVE
    } state_t;

    state_t     state_reg;
    in_t        item_reg;
    logic       out_valid_reg;
    out_t       out_data_reg;
    logic       rec_reg;

    cell_ctrl_t ctrl;
    logic       out_free;
    logic       out_load;
    out_t       result;

    logic   [PENDING_DEPTH-1:0] valid_vec;
    logic   [PENDING_DEPTH-1:0] found_vec;
    logic   [PENDING_DEPTH:0]   kill_chain;
    entry_t                     cell_entry [PENDING_DEPTH];
    entry_t                     hit_entry;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = (state_reg == S_RESOLVE) && out_free;

    assign ctrl.capture     = (state_reg == S_MATCH);
    assign ctrl.commit      = out_load && rec_reg;
    assign ctrl.is_off      = (item_reg.kind == KIND_OFF);
    assign ctrl.ev.start    = item_reg.current_tick;
    assign ctrl.ev.pitch    = item_reg.pitch;
    assign ctrl.ev.velocity = item_reg.velocity;
    assign ctrl.ev.channel  = item_reg.channel;

    assign kill_chain[0] = 1'b0;

    for (genvar i = 0; i < PENDING_DEPTH; i++)
    begin : g_cell
        logic   left_v;
        logic   right_v;
        entry_t right_e;

        if (i == 0)
        begin : g_first
            assign left_v = 1'b1;
        end
        else
        begin : g_mid
            assign left_v = valid_vec[i-1];
        end

        if (i == PENDING_DEPTH - 1)
        begin : g_last
            assign right_v = 1'b0;
            assign right_e = '0;
        end
        else
        begin : g_inner
            assign right_v = valid_vec[i+1];
            assign right_e = cell_entry[i+1];
        end

        nop_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .left_valid  (left_v),
            .kill_in     (kill_chain[i]),
            .right_valid (right_v),
            .right_entry (right_e),
            .kill_out    (kill_chain[i+1]),
            .found       (found_vec[i]),
            .valid       (valid_vec[i]),
            .entry       (cell_entry[i])
        );
    end

    // at most one cell reports found, so an OR picks its entry
    always_comb
    begin
        hit_entry = '0;
        for (int i = 0; i < PENDING_DEPTH; i++)
        begin
            hit_entry = hit_entry | (cell_entry[i] & {$bits(entry_t){found_vec[i]}});
        end
    end

    always_comb
    begin
        result = '0;
        if (!rec_reg)
        begin
            result.status = ST_DISABLED;
        end
        else if (item_reg.kind == KIND_ON)
        begin
            result.status = valid_vec[PENDING_DEPTH-1] ? ST_FULL : ST_STORED;
        end
        else if (kill_chain[PENDING_DEPTH])
        begin
            result.status        = ST_DONE;
            result.start_tick    = hit_entry.start;
            result.end_tick      = item_reg.current_tick;
            result.note_pitch    = hit_entry.pitch;
            result.note_velocity = hit_entry.velocity;
            result.note_channel  = hit_entry.channel;
        end
        else
        begin
            result.status = ST_NOMATCH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            rec_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                rec_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        item_reg  <= in_data;
                        state_reg <= S_MATCH;
                    end
                end
                S_MATCH:
                begin
                    state_reg <= S_RESOLVE;
                end
                S_RESOLVE:
                begin
                    // hold until the output register frees
                    if (out_load)
                    begin
                        out_data_reg <= result;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `NOP_ASSERT_NOW(a_valid_prefix, 1'b1, ((valid_vec >> 1) & ~valid_vec) == '0)
    `NOP_ASSERT_NOW(a_found_single, 1'b1, $onehot0(found_vec))
    `NOP_ASSERT_NEXT(a_store_grows,
        ctrl.commit && !ctrl.is_off && !valid_vec[PENDING_DEPTH-1],
        $countones(valid_vec) == $countones($past(valid_vec)) + 1)
    `NOP_ASSERT_NEXT(a_close_shrinks,
        ctrl.commit && ctrl.is_off && kill_chain[PENDING_DEPTH],
        $countones(valid_vec) + 1 == $countones($past(valid_vec)))

endmodule
